FILE: rtl/olse_pkg.sv
// Package: shared types and codes for the ordered list slot engine.
`timescale 1ns / 1ps
`default_nettype none
package olse_pkg;

	localparam int unsigned OP_W      = 3;
	localparam int unsigned POS_W     = 7;
	localparam int unsigned WDAT_W    = 32;
	localparam int unsigned SLOT_W    = 6;
	// slot pool size; positions and slot fields above are sized for it
	localparam int unsigned MAX_SLOTS = 64;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND = 3'd0,
		OP_WRITE  = 3'd1,
		OP_READ   = 3'd2,
		OP_SWAP   = 3'd3,
		OP_MOVE   = 3'd4,
		OP_REMOVE = 3'd5
	} opcode_t;

	typedef struct packed {
		logic [OP_W-1:0]   opcode;
		logic [POS_W-1:0]  pos_a;
		logic [POS_W-1:0]  pos_b;
		logic [WDAT_W-1:0] write_data;
	} cmd_t;

	typedef struct packed {
		logic              status;
		logic [WDAT_W-1:0] read_data;
		logic [POS_W-1:0]  entry_count;
		logic [SLOT_W-1:0] last_slot;
	} rsp_t;

endpackage
`default_nettype wire

FILE: rtl/ordered_list_slot_engine.sv
// Top level: sequencer working on a doubly linked list of slots held in memories.
//
// A command is taken when start is high and busy is low; busy then stays high
// until it is done. The result beat (rsp_valid, one cycle, the receiver cannot
// stall) comes in the first cycle with busy low, where the next command may
// already be taken. Range errors and writes go from the check state straight
// to the response state. Read, remove, move and swap walk forward links from
// the first slot up to the farthest position needed; append scans backward
// links slot by slot up to the capacity. After the walk a read fetches data,
// a remove unlinks and frees the slot, a move unlinks and reinserts it and a
// swap does two relocations; a swap of the last position is the longest command.
// After reset a clearing pass sweeps all MAX_SLOTS entries, busy high.
`timescale 1ns / 1ps
`default_nettype none
module ordered_list_slot_engine (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire olse_pkg::cmd_t             cmd,
	output logic                            rsp_valid,
	output olse_pkg::rsp_t                  rsp,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [olse_pkg::POS_W-1:0] cfg_data
);

	localparam int unsigned MAX_SLOTS = olse_pkg::MAX_SLOTS;
	localparam int unsigned DW = olse_pkg::WDAT_W;
	localparam int unsigned AW = $clog2(MAX_SLOTS);
	localparam int unsigned LW = AW + 1;
	localparam int unsigned CW = $clog2(MAX_SLOTS + 1);
	localparam logic [LW-1:0] NULL_L = {LW{1'b1}};

	typedef enum logic [15:0] {
		ST_CLR  = 16'h0001,
		ST_IDLE = 16'h0002,
		ST_EXEC = 16'h0004,
		ST_WALK = 16'h0008,
		ST_WAIT = 16'h0010,
		ST_SCAN = 16'h0020,
		ST_SCHK = 16'h0040,
		ST_APP  = 16'h0080,
		ST_RDAT = 16'h0100,
		ST_UNRD = 16'h0200,
		ST_UNWR = 16'h0400,
		ST_INRD = 16'h0800,
		ST_INA  = 16'h1000,
		ST_INB  = 16'h2000,
		ST_FREE = 16'h4000,
		ST_RESP = 16'h8000
	} state_t;

	state_t state_q;

	// memories
	logic          nx_we, pv_we, dt_we;
	logic [AW-1:0] nx_wa, pv_wa, dt_wa, lk_ra, dt_ra;
	logic [LW-1:0] nx_wd, pv_wd, nx_rd, pv_rd;
	logic [DW-1:0] dt_wd, dt_rd;

	olse_ram #(.DEPTH(MAX_SLOTS), .WIDTH(LW)) u_next (
		.clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd),
		.raddr(lk_ra), .rdata(nx_rd));
	olse_ram #(.DEPTH(MAX_SLOTS), .WIDTH(LW)) u_prev (
		.clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd),
		.raddr(lk_ra), .rdata(pv_rd));
	olse_ram #(.DEPTH(MAX_SLOTS), .WIDTH(DW)) u_data (
		.clk(clk), .we(dt_we), .waddr(dt_wa), .wdata(dt_wd),
		.raddr(dt_ra), .rdata(dt_rd));

	// list registers
	logic [LW-1:0] first_q, tail_q;
	logic [CW-1:0] size_q;
	logic [olse_pkg::POS_W-1:0] cap_q;

	// command and work registers
	olse_pkg::cmd_t cmd_q;
	logic [CW-1:0]  idx_q;
	logic [LW-1:0]  cur_q;
	logic [AW-1:0]  clr_q;
	logic [LW-1:0]  sa_q, sb_q;   // slots at pos_a and pos_b
	logic [LW-1:0]  x_q;          // forward link of the farthest walked slot
	logic [LW-1:0]  mv_q, tg_q;   // slot being relocated and slot it goes before
	logic [LW-1:0]  q_q;          // slot that ends up just before mv_q
	logic           swap2_q;
	logic           err_q;
	logic [DW-1:0]  rdat_q;

	logic [CW-1:0] a_w, b_w, hi_w;
	logic [CW-1:0] cap_eff;
	logic [LW-1:0] q_w, slo_w, shi_w;
	assign a_w = CW'(cmd_q.pos_a);
	assign b_w = CW'(cmd_q.pos_b);
	assign cap_eff = (32'(cap_q) > MAX_SLOTS) ? CW'(MAX_SLOTS) : CW'(cap_q);
	assign q_w   = tg_q[LW-1] ? tail_q : pv_rd;
	assign slo_w = (a_w < b_w) ? sa_q : sb_q;
	assign shi_w = (a_w < b_w) ? sb_q : sa_q;

	// farthest position the walk has to reach
	always_comb begin
		hi_w = a_w;
		if ((cmd_q.opcode == olse_pkg::OP_SWAP ||
				(cmd_q.opcode == olse_pkg::OP_MOVE && b_w < size_q)) && b_w > a_w) begin
			hi_w = b_w;
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	// memory port control
	always_comb begin
		nx_we = 1'b0; pv_we = 1'b0; dt_we = 1'b0;
		nx_wa = '0; pv_wa = '0; dt_wa = '0;
		nx_wd = NULL_L; pv_wd = NULL_L; dt_wd = '0;
		lk_ra = cur_q[AW-1:0];
		dt_ra = sa_q[AW-1:0];
		case (state_q)
			ST_CLR: begin
				nx_we = 1'b1; pv_we = 1'b1; dt_we = 1'b1;
				nx_wa = clr_q; pv_wa = clr_q; dt_wa = clr_q;
			end
			ST_EXEC: begin
				// write data to the last entry
				if (cmd_q.opcode == olse_pkg::OP_WRITE && size_q != '0) begin
					dt_we = 1'b1;
					dt_wa = tail_q[AW-1:0];
					dt_wd = cmd_q.write_data;
				end
			end
			ST_SCAN: lk_ra = AW'(idx_q);
			ST_APP: begin
				// hang the new slot behind the tail
				nx_we = !tail_q[LW-1];
				nx_wa = tail_q[AW-1:0];
				nx_wd = mv_q;
				pv_we = 1'b1;
				pv_wa = mv_q[AW-1:0];
				pv_wd = tail_q;
			end
			ST_UNRD: lk_ra = mv_q[AW-1:0];
			ST_UNWR: begin
				// bridge the neighbors of mv_q
				nx_we = !pv_rd[LW-1];
				nx_wa = pv_rd[AW-1:0];
				nx_wd = nx_rd;
				pv_we = !nx_rd[LW-1];
				pv_wa = nx_rd[AW-1:0];
				pv_wd = pv_rd;
			end
			ST_INRD: lk_ra = tg_q[AW-1:0];
			ST_INA: begin
				nx_we = 1'b1; pv_we = 1'b1;
				nx_wa = mv_q[AW-1:0]; pv_wa = mv_q[AW-1:0];
				nx_wd = tg_q;
				pv_wd = q_w;
			end
			ST_INB: begin
				nx_we = !q_q[LW-1];
				nx_wa = q_q[AW-1:0];
				nx_wd = mv_q;
				pv_we = !tg_q[LW-1];
				pv_wa = tg_q[AW-1:0];
				pv_wd = mv_q;
			end
			ST_FREE: begin
				// removed slot: null links, zero data
				nx_we = 1'b1; pv_we = 1'b1; dt_we = 1'b1;
				nx_wa = mv_q[AW-1:0]; pv_wa = mv_q[AW-1:0]; dt_wa = mv_q[AW-1:0];
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLR;
			clr_q     <= '0;
			first_q   <= NULL_L;
			tail_q    <= NULL_L;
			size_q    <= '0;
			cap_q     <= olse_pkg::POS_W'(64);
			rsp_valid <= 1'b0;
			cmd_q     <= '0;
			idx_q     <= '0;
			cur_q     <= NULL_L;
			sa_q      <= NULL_L;
			sb_q      <= NULL_L;
			x_q       <= NULL_L;
			mv_q      <= NULL_L;
			tg_q      <= NULL_L;
			q_q       <= NULL_L;
			swap2_q   <= 1'b0;
			err_q     <= 1'b0;
			rdat_q    <= '0;
		end else begin
			rsp_valid <= 1'b0;
			if (cfg_valid) begin
				cap_q <= cfg_data;
			end
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == MAX_SLOTS - 1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						cmd_q   <= cmd;
						err_q   <= 1'b0;
						rdat_q  <= '0;
						state_q <= ST_EXEC;
					end
				end
				// range checks, then start the walk or the scan, or go straight to the response
				ST_EXEC: begin
					idx_q   <= '0;
					cur_q   <= first_q;
					sb_q    <= NULL_L;
					swap2_q <= 1'b0;
					state_q <= ST_RESP;
					case (cmd_q.opcode)
						olse_pkg::OP_APPEND: begin
							if (size_q >= CW'(MAX_SLOTS) || cap_eff == '0) begin
								err_q <= 1'b1;
							end else begin
								state_q <= ST_SCAN;
							end
						end
						olse_pkg::OP_WRITE: begin
							if (size_q == '0) begin
								err_q <= 1'b1;
							end
						end
						olse_pkg::OP_READ, olse_pkg::OP_REMOVE: begin
							if (a_w >= size_q) begin
								err_q <= 1'b1;
							end else begin
								state_q <= ST_WALK;
							end
						end
						olse_pkg::OP_SWAP: begin
							if (a_w >= size_q || b_w >= size_q) begin
								err_q <= 1'b1;
							end else if (a_w != b_w) begin
								state_q <= ST_WALK;
							end
						end
						olse_pkg::OP_MOVE: begin
							if (a_w >= size_q || b_w > size_q) begin
								err_q <= 1'b1;
							end else if (a_w != b_w) begin
								state_q <= ST_WALK;
							end
						end
						default: err_q <= 1'b1;
					endcase
				end
				// walk links, one position per pass through the walk and wait states
				ST_WALK: begin
					if (idx_q == a_w) begin
						sa_q <= cur_q;
					end
					if (idx_q == b_w) begin
						sb_q <= cur_q;
					end
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (idx_q == hi_w) begin
						x_q <= nx_rd;
						case (cmd_q.opcode)
							olse_pkg::OP_READ: state_q <= ST_RDAT;
							olse_pkg::OP_SWAP: begin
								// far slot before near one, then near one to the gap
								mv_q    <= shi_w;
								tg_q    <= slo_w;
								swap2_q <= 1'b1;
								state_q <= ST_UNRD;
							end
							default: begin
								mv_q    <= sa_q;
								tg_q    <= sb_q;
								state_q <= ST_UNRD;
							end
						endcase
					end else begin
						cur_q   <= nx_rd;
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_WALK;
					end
				end
				// append: lowest slot below capacity that is not in the list
				ST_SCAN: begin
					if (idx_q >= cap_eff) begin
						err_q   <= 1'b1;
						state_q <= ST_RESP;
					end else begin
						state_q <= ST_SCHK;
					end
				end
				ST_SCHK: begin
					if (pv_rd == NULL_L && LW'(idx_q) != first_q) begin
						mv_q    <= LW'(idx_q);
						state_q <= ST_APP;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_SCAN;
					end
				end
				ST_APP: begin
					if (size_q == '0) begin
						first_q <= mv_q;
					end
					tail_q  <= mv_q;
					size_q  <= size_q + 1'b1;
					state_q <= ST_RESP;
				end
				ST_RDAT: begin
					rdat_q  <= dt_rd;
					state_q <= ST_RESP;
				end
				// unlink mv_q
				ST_UNRD: state_q <= ST_UNWR;
				ST_UNWR: begin
					if (pv_rd[LW-1]) begin
						first_q <= nx_rd;
					end
					if (nx_rd[LW-1]) begin
						tail_q <= pv_rd;
					end
					state_q <= (cmd_q.opcode == olse_pkg::OP_REMOVE) ? ST_FREE : ST_INRD;
				end
				// insert mv_q before tg_q, or at the end when tg_q is null
				ST_INRD: state_q <= ST_INA;
				ST_INA: begin
					q_q <= q_w;
					if (q_w[LW-1]) begin
						first_q <= mv_q;
					end
					if (tg_q[LW-1]) begin
						tail_q <= mv_q;
					end
					state_q <= ST_INB;
				end
				ST_INB: begin
					if (swap2_q) begin
						swap2_q <= 1'b0;
						mv_q    <= tg_q;
						tg_q    <= x_q;
						state_q <= ST_UNRD;
					end else begin
						state_q <= ST_RESP;
					end
				end
				ST_FREE: begin
					size_q  <= size_q - 1'b1;
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					rsp_valid <= 1'b1;
					state_q   <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result beat
	assign rsp.status      = err_q;
	assign rsp.read_data   = rdat_q;
	assign rsp.entry_count = olse_pkg::POS_W'(size_q);
	assign rsp.last_slot   = (size_q != '0) ? olse_pkg::SLOT_W'(tail_q) : '0;

	// a result beat lasts one cycle and follows the response state
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> $past(state_q == ST_RESP))
		else $error("result beat without response state");
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |=> !rsp_valid)
		else $error("result beat longer than one cycle");
	assert property (@(posedge clk) disable iff (!arst_n)
		(size_q <= CW'(MAX_SLOTS)))
		else $error("count beyond pool size");

endmodule
`default_nettype wire

FILE: rtl/olse_ram.sv
// Simple dual-port memory (one write port, one read port) with registered read, used for links and data.
`timescale 1ns / 1ps
`default_nettype none
module olse_ram #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned WIDTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

FILE: tb/ordered_list_slot_engine_checker.sv
// Checker: watches command, response and config beats, predicts list results and compares.
`timescale 1ns / 1ps
module ordered_list_slot_engine_checker
	import olse_pkg::*;
#(
	parameter int unsigned MAX_SLOTS = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic                 busy,
	input  wire cmd_t                 cmd,
	input  wire logic                 rsp_valid,
	input  wire rsp_t                 rsp,
	input  wire logic                 cfg_valid,
	input  wire logic                 cfg_ready,
	input  wire logic [POS_W-1:0]     cfg_data,
	output int                        fail_count,
	output int                        pending_count
);

	localparam logic [6:0] NIL = 7'h7f;

	// shadow list state
	logic [6:0]  nxt [MAX_SLOTS];
	logic [6:0]  prv [MAX_SLOTS];
	logic [31:0] dat [MAX_SLOTS];
	logic [6:0]  head_s, tail_s, size_s, cap_s;
	rsp_t        rsp_queue [$];

	function automatic void relink_order(ref logic [6:0] order [MAX_SLOTS], input int n);
		for (int i = 0; i < n; i++) begin
			prv[order[i]] = (i == 0) ? NIL : order[i-1];
			nxt[order[i]] = (i + 1 == n) ? NIL : order[i+1];
		end
		head_s = (n > 0) ? order[0] : NIL;
		tail_s = (n > 0) ? order[n-1] : NIL;
		size_s = 7'(n);
	endfunction

	function automatic rsp_t list_result(cmd_t c);
		logic [6:0] order [MAX_SLOTS];
		logic [6:0] s, slot, found;
		int n, ins, capn;
		logic err;
		logic [31:0] rd;
		rsp_t r;
		n = 0; s = head_s; err = 0; rd = '0;
		while (n < size_s && n < MAX_SLOTS && s < MAX_SLOTS) begin
			order[n] = s; n++; s = nxt[s];
		end
		case (c.opcode)
			OP_APPEND: begin
				capn = (cap_s > MAX_SLOTS) ? MAX_SLOTS : cap_s;
				found = NIL;
				for (int i = capn - 1; i >= 0; i--)
					if (prv[i] == NIL && 7'(i) != head_s) found = 7'(i);
				if (found == NIL || n >= MAX_SLOTS) err = 1;
				else begin
					order[n] = found;
					relink_order(order, n + 1);
				end
			end
			OP_WRITE: begin
				if (n == 0 || tail_s >= MAX_SLOTS) err = 1;
				else dat[tail_s] = c.write_data;
			end
			OP_READ: begin
				if (c.pos_a >= n) err = 1;
				else rd = dat[order[c.pos_a]];
			end
			OP_SWAP: begin
				if (c.pos_a >= n || c.pos_b >= n) err = 1;
				else if (c.pos_a != c.pos_b) begin
					slot = order[c.pos_a];
					order[c.pos_a] = order[c.pos_b];
					order[c.pos_b] = slot;
					relink_order(order, n);
				end
			end
			OP_MOVE: begin
				if (c.pos_a >= n || c.pos_b > n) err = 1;
				else if (c.pos_a != c.pos_b) begin
					slot = order[c.pos_a];
					ins = (c.pos_b > c.pos_a) ? c.pos_b - 1 : c.pos_b;
					for (int i = c.pos_a; i < n - 1; i++) order[i] = order[i+1];
					for (int i = n - 1; i > ins; i--) order[i] = order[i-1];
					order[ins] = slot;
					relink_order(order, n);
				end
			end
			OP_REMOVE: begin
				if (c.pos_a >= n) err = 1;
				else begin
					slot = order[c.pos_a];
					for (int i = c.pos_a; i < n - 1; i++) order[i] = order[i+1];
					nxt[slot] = NIL; prv[slot] = NIL; dat[slot] = '0;
					relink_order(order, n - 1);
				end
			end
			default: err = 1;
		endcase
		r.status = err;
		r.read_data = rd;
		r.entry_count = size_s;
		r.last_slot = (size_s != 0) ? tail_s[5:0] : '0;
		return r;
	endfunction

	assign pending_count = rsp_queue.size();

	// predict on accepted commands, compare on response strobes
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			for (int i = 0; i < MAX_SLOTS; i++) begin
				nxt[i] = NIL; prv[i] = NIL; dat[i] = '0;
			end
			head_s = NIL; tail_s = NIL; size_s = '0; cap_s = 7'd64;
			rsp_queue.delete();
			fail_count = 0;
		end else begin
			if (rsp_valid) begin
				if (rsp_queue.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected response beat: %p", rsp);
				end else begin
					want = rsp_queue.pop_front();
					if (rsp.status !== want.status || rsp.read_data !== want.read_data ||
							rsp.entry_count !== want.entry_count ||
							rsp.last_slot !== want.last_slot) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected %p actual %p", want, rsp);
					end
				end
			end
			if (start && !busy)
				rsp_queue.push_back(list_result(cmd));
			if (cfg_valid && cfg_ready)
				cap_s = cfg_data;
		end
	end

endmodule

FILE: tb/ordered_list_slot_engine_tb.sv
// Testbench top: drives list commands and capacity writes, reports the verdict.
`timescale 1ns / 1ps
module ordered_list_slot_engine_tb;
	import olse_pkg::*;

	localparam int LIMIT = 3000000;

	logic             clk = 0;
	logic             arst_n = 0;
	logic             start = 0;
	logic             busy;
	cmd_t             cmd = '0;
	logic             rsp_valid;
	rsp_t             rsp;
	logic             cfg_valid = 0;
	logic             cfg_ready;
	logic [POS_W-1:0] cfg_data = '0;
	int               fail_count, pending_count;
	int               cycles = 0;
	int               model_size = 0;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	ordered_list_slot_engine DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.rsp_valid(rsp_valid), .rsp(rsp), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	ordered_list_slot_engine_checker CHK (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.rsp_valid(rsp_valid), .rsp(rsp), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// one command beat, after a random gap
	task automatic issue(input logic [2:0] op, input logic [6:0] a, input logic [6:0] b,
			input logic [31:0] wd);
		int gap;
		gap = $urandom_range(0, 15);
		repeat (gap) @(negedge clk);
		cmd = {op, a, b, wd};
		start = 1;
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
		start = 0;
	endtask

	task automatic drain();
		while (pending_count != 0) @(negedge clk);
		repeat (400) @(negedge clk);
	endtask

	task automatic set_capacity(input logic [6:0] v);
		drain();
		cfg_data = v;
		cfg_valid = 1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid = 0;
	endtask

	// mostly legal positions against a rough count, some out of range
	function automatic logic [6:0] pick_pos(int n, bit allow_end);
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 7'($urandom_range(0, 127));
		if (n == 0) return 7'(allow_end ? 0 : $urandom_range(0, 2));
		return 7'($urandom_range(0, allow_end ? n : n - 1));
	endfunction

	task automatic random_phase(int items, int fill_bias);
		logic [2:0] op;
		int r;
		for (int k = 0; k < items; k++) begin
			r = $urandom_range(0, 99);
			if (r < fill_bias) op = OP_APPEND;
			else if (r < 97) op = 3'($urandom_range(1, 5));
			else op = 3'($urandom_range(6, 7));
			issue(op, pick_pos(model_size, 0),
				pick_pos(model_size, op == OP_MOVE), $urandom());
			model_size = CHK.rsp_queue.size() >= 0 ? CHK.size_s : 0;
		end
	endtask

	initial begin
		repeat (7) @(negedge clk);
		arst_n = 1;
		// directed: empty list errors, fills, extremes
		issue(OP_READ, 0, 0, 0);
		issue(OP_WRITE, 0, 0, 32'hffff_ffff);
		issue(OP_REMOVE, 0, 0, 0);
		issue(OP_SWAP, 0, 0, 0);
		issue(OP_MOVE, 0, 0, 0);
		issue(3'd6, 7'h7f, 7'h7f, 32'hffff_ffff);
		issue(3'd7, 0, 0, 0);
		for (int i = 0; i < 4; i++) begin
			issue(OP_APPEND, 0, 0, 0);
			issue(OP_WRITE, 0, 0, i[0] ? 32'hffff_ffff : 32'h5a5a_0000 + i);
		end
		issue(OP_READ, 3, 0, 0);
		issue(OP_READ, 4, 0, 0);
		issue(OP_SWAP, 0, 3, 0);
		issue(OP_SWAP, 2, 2, 0);
		issue(OP_MOVE, 0, 4, 0);
		issue(OP_MOVE, 3, 0, 0);
		issue(OP_MOVE, 1, 5, 0);
		issue(OP_REMOVE, 1, 0, 0);
		issue(OP_REMOVE, 7'h7f, 0, 0);
		issue(OP_APPEND, 0, 0, 0);
		model_size = CHK.size_s;
		// capacity extremes; fill against small capacity
		set_capacity(7'd1);
		issue(OP_APPEND, 0, 0, 0);
		issue(OP_APPEND, 0, 0, 0);
		set_capacity(7'd0);
		issue(OP_APPEND, 0, 0, 0);
		set_capacity(7'd127);
		random_phase(80, 60);
		drain();
		// small working lists, mostly
		set_capacity(7'd8);
		random_phase(180, 30);
		set_capacity(7'($urandom_range(1, 64)));
		random_phase(150, 35);
		set_capacity(7'd64);
		random_phase(120, 40);
		set_capacity(7'($urandom_range(0, 127)));
		random_phase(120, 25);
		drain();
		if (fail_count == 0 && pending_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/olse_pkg.sv
rtl/olse_ram.sv
rtl/ordered_list_slot_engine.sv
tb/ordered_list_slot_engine_checker.sv
tb/ordered_list_slot_engine_tb.sv
